>>> sv/brf_pkg.sv
// Package: shared types, codes and saturating fixed-point helpers of the Broyden root finder.
`timescale 1ns / 1ps

package brf_pkg;

    localparam int DATA_W = 32;
    localparam int STEP_W = 31;
    localparam int ITER_W = 17;
    localparam int MAXIT_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_VALUE = 1'b1;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_SINGULAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 2'd3;

    typedef struct packed {
        logic        start;
        logic        neg;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic signed [31:0] quot;
    } t_div_rsp;

    // Clamp a wide signed value into the 32-bit range.
    function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'sh0_0000_0000_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -66'sh0_0000_0000_8000_0000) begin
            res = -32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Apply a sign to a magnitude and clamp.
    function automatic logic signed [31:0] sat_mag(input logic [63:0] mag, input logic neg);
        logic signed [31:0] res;
        if (neg) begin
            if (mag >= 64'h8000_0000) begin
                res = -32'sh8000_0000;
            end else begin
                res = -$signed(mag[31:0]);
            end
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                res = 32'sh7FFF_FFFF;
            end else begin
                res = mag[31:0];
            end
        end
        return res;
    endfunction

    function automatic logic [63:0] abs66(input logic signed [65:0] v);
        logic signed [65:0] a;
        a = (v < 0) ? -v : v;
        return a[63:0];
    endfunction

    // Q16.16 product rounded on its magnitude, halves away from zero.
    function automatic logic signed [31:0] mul_round(input logic signed [63:0] p);
        logic [63:0] mag;
        logic [63:0] rnd;
        mag = (p < 0) ? 64'(-p) : 64'(p);
        rnd = (mag + 64'h8000) >> 16;
        return sat_mag(rnd, p < 0);
    endfunction

endpackage

>>> sv/brf_in_if.sv
// Interface: input channel of the root finder (start or function value words).
`timescale 1ns / 1ps

interface brf_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;

    modport source (output valid, op, start_x, start_y, value_x, value_y, input ready);
    modport sink (input valid, op, start_x, start_y, value_x, value_y, output ready);
endinterface

>>> sv/brf_out_if.sv
// Interface: result channel of the root finder (requests and finish words).
`timescale 1ns / 1ps

interface brf_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [1:0]         status;
    logic [16:0]        iterations;

    modport source (output valid, kind, point_x, point_y, status, iterations, input ready);
    modport sink (input valid, kind, point_x, point_y, status, iterations, output ready);
endinterface

>>> sv/brf_mul.sv
// Module: registered 32 by 32 signed multiplier shared by the sequencer.
`timescale 1ns / 1ps

module brf_mul
    import brf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_p
);

    logic signed [63:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= 64'(i_a) * 64'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

>>> sv/brf_div.sv
// Module: bit-serial Q16.16 divider with rounding and saturation.
`timescale 1ns / 1ps

module brf_div
    import brf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEPS = 33;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic [63:0]        r_rem;
    logic [32:0]        r_sh;
    logic [32:0]        r_q;
    logic               r_neg;
    logic [63:0]        r_den;
    logic signed [31:0] r_quot;

    logic [64:0] trial;
    logic        ge;
    logic [63:0] n_rem;
    logic [32:0] n_q;
    logic [33:0] n_mag;
    logic        ovf;

    assign trial = {r_rem, r_sh[32]};
    assign ge = trial >= {1'b0, r_den};
    assign n_rem = ge ? 64'(trial - {1'b0, r_den}) : trial[63:0];
    assign n_q = {r_q[31:0], ge};
    assign n_mag = ({1'b0, n_q} + 34'd1) >> 1;
    // A quotient of 2^32 or more saturates whatever the rounding.
    assign ovf = {16'd0, i_req.num} >= {i_req.den, 16'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_neg <= i_req.neg;
            r_den <= i_req.den;
            r_q <= '0;
            r_cnt <= CNT_W'(STEPS);
            if (ovf) begin
                r_busy <= 1'b0;
                r_quot <= sat_mag(64'h1_0000_0000, i_req.neg);
            end else begin
                r_busy <= 1'b1;
                r_rem <= {16'd0, i_req.num[63:16]};
                r_sh <= {i_req.num[15:0], 17'd0};
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sh <= {r_sh[31:0], 1'b0};
            r_q <= n_q;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_quot <= sat_mag({30'd0, n_mag}, (n_mag != 34'd0) && r_neg);
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_quot;

endmodule

>>> sv/broyden_root_finder_2d.sv
// Top level: Broyden root finder sequencer around a shared multiplier and divider.
`timescale 1ns / 1ps

//  channel   direction  carries
//  i_in      in         op, start point, function value at the requested point
//  o_out     out        next point to evaluate, or finish word with status
//  i_cfg_*   in         step_x, step_y, tolerance, max_iterations writes
//
// Start words, the first value word and the plus-side sample of each
// finite-difference pair go straight to a result. A central-difference word
// costs two serial divides; the loop test adds multiplier products and two
// divides, and an update word adds multiplier products plus four divides.
// Reset is synchronous and active low; a word waiting on o_out holds the
// sequencer in its emit state, while i_in is ready only when the sequencer idles.

module broyden_root_finder_2d
    import brf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    brf_in_if.sink               i_in,
    brf_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [STEP_W-1:0]    i_cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_F0, PH_XP, PH_XM, PH_YP, PH_YM, PH_UPD, PH_DONE
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE, S_EMIT, S_CX0, S_CX1, S_CX2,
        S_LC0, S_LC1, S_LC2, S_LC3, S_LC4, S_LC5, S_LC6, S_LC7, S_LC8, S_LC9,
        S_LW0, S_LW1,
        S_U0, S_U1, S_U2, S_U3, S_U4, S_U5, S_U6, S_U7, S_U8, S_U9, S_U10
    } t_state;

    t_state r_state;
    t_phase r_phase;

    logic [STEP_W-1:0]  r_step_x;
    logic [STEP_W-1:0]  r_step_y;
    logic [STEP_W-1:0]  r_tol;
    logic [MAXIT_W-1:0] r_maxit;

    logic signed [31:0] r_cp [2];
    logic signed [31:0] r_cv [2];
    logic signed [31:0] r_np [2];
    logic signed [31:0] r_pv [2];
    logic signed [31:0] r_vin [2];
    logic signed [31:0] r_jac [4];
    logic signed [31:0] r_dx [2];
    logic signed [31:0] r_dy [2];
    logic signed [31:0] r_res [2];
    logic [ITER_W-1:0]  r_it;

    logic signed [65:0] r_acc;
    logic [63:0]        r_dm;
    logic               r_dneg;
    logic [63:0]        r_n1m;
    logic               r_n1s;
    logic [63:0]        r_norm;
    logic [1:0]         r_k;

    // Staged result and the output register behind it.
    logic               r_rk;
    logic signed [31:0] r_rx;
    logic signed [31:0] r_ry;
    logic [1:0]         r_rst;
    logic [ITER_W-1:0]  r_rit;
    logic               r_ov;
    logic               r_ok;
    logic signed [31:0] r_ox;
    logic signed [31:0] r_oy;
    logic [1:0]         r_ost;
    logic [ITER_W-1:0]  r_oit;

    logic               mul_en;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;
    logic signed [65:0] prod66;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic [STEP_W-1:0]  sx_eff;
    logic [STEP_W-1:0]  sy_eff;
    logic [STEP_W-1:0]  s_cur;
    logic signed [32:0] cdiff;
    logic signed [65:0] diff66;
    logic signed [31:0] n_val;

    brf_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    brf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // A zero step register acts as the smallest step.
    assign sx_eff = (r_step_x == '0) ? STEP_W'(1) : r_step_x;
    assign sy_eff = (r_step_y == '0) ? STEP_W'(1) : r_step_y;
    assign s_cur = (r_phase == PH_XM) ? sx_eff : sy_eff;
    assign prod66 = 66'(prod);
    assign diff66 = r_acc - prod66;

    // Difference of the plus-side and minus-side samples of the current component.
    always_comb begin
        if (r_state == S_CX0) begin
            cdiff = 33'(r_pv[0]) - 33'(r_vin[0]);
        end else begin
            cdiff = 33'(r_pv[1]) - 33'(r_vin[1]);
        end
    end

    // Multiplier operand selection by sequencer step.
    always_comb begin
        mul_en = 1'b1;
        mul_a = r_cv[0];
        mul_b = r_cv[0];
        case (r_state)
            S_LC0: begin mul_a = r_cv[0]; mul_b = r_cv[0]; end
            S_LC1: begin mul_a = r_cv[1]; mul_b = r_cv[1]; end
            S_LC2: begin mul_a = $signed({1'b0, r_tol}); mul_b = $signed({1'b0, r_tol}); end
            S_LC3: begin mul_a = r_jac[0]; mul_b = r_jac[3]; end
            S_LC4: begin mul_a = r_jac[1]; mul_b = r_jac[2]; end
            S_LC5: begin mul_a = r_jac[3]; mul_b = r_cv[0]; end
            S_LC6: begin mul_a = r_jac[1]; mul_b = r_cv[1]; end
            S_LC7: begin mul_a = r_jac[0]; mul_b = r_cv[1]; end
            S_LC8: begin mul_a = r_jac[2]; mul_b = r_cv[0]; end
            S_U1:  begin mul_a = r_dx[0]; mul_b = r_dx[0]; end
            S_U2:  begin mul_a = r_dx[1]; mul_b = r_dx[1]; end
            S_U3:  begin mul_a = r_jac[0]; mul_b = r_dx[0]; end
            S_U4:  begin mul_a = r_jac[1]; mul_b = r_dx[1]; end
            S_U5:  begin mul_a = r_jac[2]; mul_b = r_dx[0]; end
            S_U6:  begin mul_a = r_jac[3]; mul_b = r_dx[1]; end
            S_U8:  begin mul_a = r_res[r_k[1]]; mul_b = r_dx[r_k[0]]; end
            default: mul_en = 1'b0;
        endcase
    end

    // Divider request by sequencer step.
    always_comb begin
        div_req.start = 1'b0;
        div_req.neg = 1'b0;
        div_req.num = '0;
        div_req.den = 64'd1;
        case (r_state)
            S_CX0: begin
                div_req.start = 1'b1;
                div_req.neg = cdiff < 0;
                div_req.num = abs66(66'(cdiff));
                div_req.den = {32'd0, s_cur, 1'b0};
            end
            S_CX1: begin
                div_req.start = !div_rsp.busy;
                div_req.neg = cdiff < 0;
                div_req.num = abs66(66'(cdiff));
                div_req.den = {32'd0, s_cur, 1'b0};
            end
            S_LC7: begin
                div_req.start = 1'b1;
                div_req.neg = (diff66 < 0) ^ r_dneg;
                div_req.num = abs66(diff66);
                div_req.den = r_dm;
            end
            S_LW0: begin
                div_req.start = !div_rsp.busy;
                div_req.neg = r_n1s ^ r_dneg;
                div_req.num = r_n1m;
                div_req.den = r_dm;
            end
            S_U9: begin
                div_req.start = 1'b1;
                div_req.neg = prod < 0;
                div_req.num = abs66(prod66);
                div_req.den = r_norm;
            end
            default: div_req.start = 1'b0;
        endcase
    end

    // Signed Q16.16 sum of the accumulator and the rounded product.
    assign n_val = sat66(r_acc + 66'(mul_round(prod)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
            r_ov <= 1'b0;
            r_it <= '0;
            r_step_x <= STEP_W'(66);
            r_step_y <= STEP_W'(66);
            r_tol <= STEP_W'(7);
            r_maxit <= MAXIT_W'(100);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_STEP_X: r_step_x <= i_cfg_data;
                    CFG_STEP_Y: r_step_y <= i_cfg_data;
                    CFG_TOLERANCE: r_tol <= i_cfg_data;
                    CFG_MAX_ITER: r_maxit <= i_cfg_data[MAXIT_W-1:0];
                    default: r_maxit <= r_maxit;
                endcase
            end

            // The emit state owns the output register while it is active.
            if (o_out.ready && r_state != S_EMIT) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_vin[0] <= i_in.value_x;
                        r_vin[1] <= i_in.value_y;
                        r_rk <= KIND_REQUEST;
                        r_rst <= ST_OK;
                        r_rit <= '0;
                        if (i_in.op == OP_START) begin
                            r_cp[0] <= i_in.start_x;
                            r_cp[1] <= i_in.start_y;
                            r_np[0] <= i_in.start_x;
                            r_np[1] <= i_in.start_y;
                            r_it <= '0;
                            r_phase <= PH_F0;
                            r_rx <= i_in.start_x;
                            r_ry <= i_in.start_y;
                            r_state <= S_EMIT;
                        end else begin
                            case (r_phase)
                                PH_F0: begin
                                    r_cv[0] <= i_in.value_x;
                                    r_cv[1] <= i_in.value_y;
                                    r_phase <= PH_XP;
                                    r_rx <= sat66(66'(r_cp[0]) + 66'({1'b0, sx_eff}));
                                    r_ry <= r_cp[1];
                                    r_state <= S_EMIT;
                                end
                                PH_XP: begin
                                    r_pv[0] <= i_in.value_x;
                                    r_pv[1] <= i_in.value_y;
                                    r_phase <= PH_XM;
                                    r_rx <= sat66(66'(r_cp[0]) - 66'({1'b0, sx_eff}));
                                    r_ry <= r_cp[1];
                                    r_state <= S_EMIT;
                                end
                                PH_YP: begin
                                    r_pv[0] <= i_in.value_x;
                                    r_pv[1] <= i_in.value_y;
                                    r_phase <= PH_YM;
                                    r_rx <= r_cp[0];
                                    r_ry <= sat66(66'(r_cp[1]) - 66'({1'b0, sy_eff}));
                                    r_state <= S_EMIT;
                                end
                                PH_XM, PH_YM: r_state <= S_CX0;
                                PH_UPD: r_state <= S_U0;
                                default: r_state <= S_IDLE;
                            endcase
                        end
                    end
                end

                S_EMIT: begin
                    if (!r_ov || o_out.ready) begin
                        r_ov <= 1'b1;
                        r_ok <= r_rk;
                        r_ox <= r_rx;
                        r_oy <= r_ry;
                        r_ost <= r_rst;
                        r_oit <= r_rit;
                        r_state <= S_IDLE;
                    end
                end

                // Central differences: first row, then second row of one column.
                S_CX0: r_state <= S_CX1;
                S_CX1: begin
                    if (!div_rsp.busy) begin
                        if (r_phase == PH_XM) begin
                            r_jac[0] <= div_rsp.quot;
                        end else begin
                            r_jac[1] <= div_rsp.quot;
                        end
                        r_state <= S_CX2;
                    end
                end
                S_CX2: begin
                    if (!div_rsp.busy) begin
                        if (r_phase == PH_XM) begin
                            r_jac[2] <= div_rsp.quot;
                            r_phase <= PH_YP;
                            r_rx <= r_cp[0];
                            r_ry <= sat66(66'(r_cp[1]) + 66'({1'b0, sy_eff}));
                            r_state <= S_EMIT;
                        end else begin
                            r_jac[3] <= div_rsp.quot;
                            r_state <= S_LC0;
                        end
                    end
                end

                // Loop test: residual norm, iteration limit, determinant, Newton step.
                S_LC0: r_state <= S_LC1;
                S_LC1: begin
                    r_acc <= prod66;
                    r_state <= S_LC2;
                end
                S_LC2: begin
                    r_acc <= r_acc + prod66;
                    r_state <= S_LC3;
                end
                S_LC3: begin
                    r_rk <= KIND_DONE;
                    r_rx <= r_cp[0];
                    r_ry <= r_cp[1];
                    r_rit <= r_it;
                    if (r_acc <= prod66) begin
                        r_rst <= ST_OK;
                        r_phase <= PH_DONE;
                        r_state <= S_EMIT;
                    end else if (r_it > ITER_W'(r_maxit)) begin
                        r_rst <= ST_LIMIT;
                        r_phase <= PH_DONE;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_LC4;
                    end
                end
                S_LC4: begin
                    r_acc <= prod66;
                    r_state <= S_LC5;
                end
                S_LC5: begin
                    r_dm <= abs66(diff66);
                    r_dneg <= diff66 < 0;
                    if (diff66 == '0) begin
                        r_rst <= ST_SINGULAR;
                        r_phase <= PH_DONE;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_LC6;
                    end
                end
                S_LC6: begin
                    r_acc <= prod66;
                    r_state <= S_LC7;
                end
                S_LC7: r_state <= S_LC8;
                S_LC8: begin
                    r_acc <= prod66;
                    r_state <= S_LC9;
                end
                S_LC9: begin
                    r_n1m <= abs66(diff66);
                    r_n1s <= diff66 < 0;
                    r_state <= S_LW0;
                end
                S_LW0: begin
                    if (!div_rsp.busy) begin
                        r_np[0] <= sat66(66'(r_cp[0]) - 66'(div_rsp.quot));
                        r_state <= S_LW1;
                    end
                end
                S_LW1: begin
                    if (!div_rsp.busy) begin
                        r_np[1] <= sat66(66'(r_cp[1]) - 66'(div_rsp.quot));
                        r_rk <= KIND_REQUEST;
                        r_rst <= ST_OK;
                        r_rit <= '0;
                        r_rx <= r_np[0];
                        r_ry <= sat66(66'(r_cp[1]) - 66'(div_rsp.quot));
                        r_phase <= PH_UPD;
                        r_state <= S_EMIT;
                    end
                end

                // Rank-one update of the Jacobian from the new sample.
                S_U0: begin
                    r_dx[0] <= sat66(66'(r_np[0]) - 66'(r_cp[0]));
                    r_dx[1] <= sat66(66'(r_np[1]) - 66'(r_cp[1]));
                    r_dy[0] <= sat66(66'(r_vin[0]) - 66'(r_cv[0]));
                    r_dy[1] <= sat66(66'(r_vin[1]) - 66'(r_cv[1]));
                    r_state <= S_U1;
                end
                S_U1: r_state <= S_U2;
                S_U2: begin
                    r_acc <= prod66;
                    r_state <= S_U3;
                end
                S_U3: begin
                    r_norm <= 64'(r_acc + prod66);
                    if (r_acc + prod66 == '0) begin
                        // The step did not move the point: the update is not counted.
                        r_rk <= KIND_DONE;
                        r_rx <= r_cp[0];
                        r_ry <= r_cp[1];
                        r_rit <= r_it;
                        r_rst <= ST_SINGULAR;
                        r_phase <= PH_DONE;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_U4;
                    end
                end
                S_U4: begin
                    r_acc <= 66'(mul_round(prod));
                    r_state <= S_U5;
                end
                S_U5: begin
                    r_res[0] <= sat66(66'(r_dy[0]) - 66'(n_val));
                    r_state <= S_U6;
                end
                S_U6: begin
                    r_acc <= 66'(mul_round(prod));
                    r_state <= S_U7;
                end
                S_U7: begin
                    r_res[1] <= sat66(66'(r_dy[1]) - 66'(n_val));
                    r_k <= '0;
                    r_state <= S_U8;
                end
                S_U8: r_state <= S_U9;
                S_U9: r_state <= S_U10;
                S_U10: begin
                    if (!div_rsp.busy) begin
                        r_jac[r_k] <= sat66(66'(r_jac[r_k]) + 66'(div_rsp.quot));
                        r_k <= r_k + 1'b1;
                        if (r_k == 2'd3) begin
                            r_it <= r_it + 1'b1;
                            r_cp[0] <= r_np[0];
                            r_cp[1] <= r_np[1];
                            r_cv[0] <= r_vin[0];
                            r_cv[1] <= r_vin[1];
                            r_state <= S_LC0;
                        end else begin
                            r_state <= S_U8;
                        end
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.kind = r_ok;
    assign o_out.point_x = r_ox;
    assign o_out.point_y = r_oy;
    assign o_out.status = r_ost;
    assign o_out.iterations = r_oit;

`ifndef SYNTHESIS
    // The divider is idle whenever a new word may enter.
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !div_rsp.busy)
        else $error("divider busy while sequencer idle");

    // A divide is never launched over one still running.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divide started while busy");

    // Request words carry no status and no iteration count.
    a_req_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ok == KIND_REQUEST) |-> (r_ost == ST_OK && r_oit == '0))
        else $error("request word with status");

    // An update word always passes through the difference step first.
    a_upd_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_U1) |-> ($past(r_state) == S_U0))
        else $error("update entered out of order");
`endif

endmodule
